[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is low
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property checked on the following clock
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/htdr_pkg.sv]
package htdr_pkg;

   localparam int KEY_W   = 64;
   localparam int MOVE_W  = 16;
   localparam int SCORE_W = 32;
   localparam int DEPTH_W = 8;
   localparam int EVAL_W  = 16;
   localparam int BOUND_W = 2;
   localparam int CNT_W   = 10;
   localparam int CFG_W   = 17;
   localparam int DATA_W  = KEY_W + MOVE_W + SCORE_W + DEPTH_W + EVAL_W + BOUND_W;

   localparam logic KIND_PROBE = 1'b0;
   localparam logic KIND_STORE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_DECIDE,
      ST_OUTPUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic div_step;
      logic rd_en;
      logic commit;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic div_done;
   } status_type;

endpackage

[hw/rtl/hash_table_depth_replace_top.sv]
// Direct-mapped search hash table with depth-preferred replacement.
// Input channel req_*: one beat carries a probe (kind 0) or a store
// (kind 1) with a 64-bit key and entry payload. Result channel rsp_*:
// one beat per request with hit, written, slot contents after the step
// and the occupied count over the first sample slots.
// Slot index is key modulo csr_entry_count (0 treated as 1, values
// above the table size saturate), written via csr_write/csr_entry_count.
// Path: the bit-serial remainder unit (64 steps, then a done step that
// issues the registered table read), the read state, and a decide/write
// state that also loads the result. One request is in flight at a time:
// a new beat is taken only after the last result has been taken.
// Reset clears the control and the occupied count, then a clearing pass
// writes every table word (ENTRIES, 65536 by default) to the empty
// entry, during which req_stall stays high.
// A stalled result holds until taken; no new request is accepted
// meanwhile.
module hash_table_depth_replace_top
   import htdr_pkg::*;
#(
   parameter int ENTRIES      = 65536,
   parameter int FILL_SAMPLE  = 1000,
   parameter int NO_MOVE_CODE = 0,
   parameter int EXACT_CODE   = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CFG_W-1:0]          csr_entry_count,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [KEY_W-1:0]          req_key,
   input  logic [MOVE_W-1:0]         req_move_code,
   input  logic signed [SCORE_W-1:0] req_move_score,
   input  logic signed [DEPTH_W-1:0] req_search_depth,
   input  logic signed [EVAL_W-1:0]  req_eval_value,
   input  logic [BOUND_W-1:0]        req_bound_type,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic                      rsp_written,
   output logic [KEY_W-1:0]          rsp_slot_key,
   output logic [MOVE_W-1:0]         rsp_slot_move,
   output logic signed [SCORE_W-1:0] rsp_slot_score,
   output logic signed [DEPTH_W-1:0] rsp_slot_depth,
   output logic signed [EVAL_W-1:0]  rsp_slot_eval,
   output logic [BOUND_W-1:0]        rsp_slot_bound,
   output logic [CNT_W-1:0]          rsp_fill_count
);

   cmd_type    cmd;
   status_type status;

   htdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   htdr_dpath #(
      .ENTRIES      (ENTRIES),
      .FILL_SAMPLE  (FILL_SAMPLE),
      .NO_MOVE_CODE (NO_MOVE_CODE),
      .EXACT_CODE   (EXACT_CODE)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_entry_count  (csr_entry_count),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_move_code    (req_move_code),
      .req_move_score   (req_move_score),
      .req_search_depth (req_search_depth),
      .req_eval_value   (req_eval_value),
      .req_bound_type   (req_bound_type),
      .rsp_hit          (rsp_hit),
      .rsp_written      (rsp_written),
      .rsp_slot_key     (rsp_slot_key),
      .rsp_slot_move    (rsp_slot_move),
      .rsp_slot_score   (rsp_slot_score),
      .rsp_slot_depth   (rsp_slot_depth),
      .rsp_slot_eval    (rsp_slot_eval),
      .rsp_slot_bound   (rsp_slot_bound),
      .rsp_fill_count   (rsp_fill_count)
   );

endmodule

[hw/rtl/htdr_ram.sv]
module htdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/htdr_ctrl.sv]
module htdr_ctrl
   import htdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

`include "assert_macros.svh"

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_done) state_in = ST_READ;
         ST_READ:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUTPUT;
         ST_OUTPUT: if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = !status.div_done;
            cmd.rd_en    = status.div_done;
         end
         ST_READ: begin
            cmd.commit   = 1'b0;
         end
         ST_DECIDE: begin
            cmd.commit   = 1'b1;
            cmd.rsp_load = 1'b1;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `ASSERT_NEXT(a_commit_then_out, clock, reset, cmd.commit, rsp_valid,
      "commit not followed by result")
   `ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid, req_stall,
      "input taken while result pending")
   `ASSERT_NEXT(a_out_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result dropped under stall")

endmodule

[hw/rtl/htdr_dpath.sv]
module htdr_dpath
   import htdr_pkg::*;
#(
   parameter int ENTRIES      = 65536,
   parameter int FILL_SAMPLE  = 1000,
   parameter int NO_MOVE_CODE = 0,
   parameter int EXACT_CODE   = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CFG_W-1:0]          csr_entry_count,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      req_kind,
   input  logic [KEY_W-1:0]          req_key,
   input  logic [MOVE_W-1:0]         req_move_code,
   input  logic signed [SCORE_W-1:0] req_move_score,
   input  logic signed [DEPTH_W-1:0] req_search_depth,
   input  logic signed [EVAL_W-1:0]  req_eval_value,
   input  logic [BOUND_W-1:0]        req_bound_type,
   output logic                      rsp_hit,
   output logic                      rsp_written,
   output logic [KEY_W-1:0]          rsp_slot_key,
   output logic [MOVE_W-1:0]         rsp_slot_move,
   output logic signed [SCORE_W-1:0] rsp_slot_score,
   output logic signed [DEPTH_W-1:0] rsp_slot_depth,
   output logic signed [EVAL_W-1:0]  rsp_slot_eval,
   output logic [BOUND_W-1:0]        rsp_slot_bound,
   output logic [CNT_W-1:0]          rsp_fill_count
);

   localparam int AW    = $clog2(ENTRIES);
   localparam int DW    = AW + 1;
   localparam int DCW   = $clog2(KEY_W + 1);
   localparam logic [DW-1:0] ENT_MAX = DW'(ENTRIES);
   localparam logic [MOVE_W-1:0] NO_MOVE = MOVE_W'(NO_MOVE_CODE);
   localparam logic [BOUND_W-1:0] EXACT = BOUND_W'(EXACT_CODE);
   localparam logic [DATA_W-1:0] EMPTY_WORD = {KEY_W'(0), NO_MOVE, SCORE_W'(0),
                                                DEPTH_W'(0), EVAL_W'(0), BOUND_W'(0)};

   // configuration register
   logic [CFG_W-1:0] entry_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= CFG_W'(65536);
      end else if (csr_write) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   // effective divisor: zero as one, saturate at table size
   logic [DW-1:0] divisor;
   always_comb begin
      if (entry_count_ff == '0) begin
         divisor = DW'(1);
      end else if (32'(entry_count_ff) > 32'(ENTRIES)) begin
         divisor = ENT_MAX;
      end else begin
         divisor = DW'(entry_count_ff);
      end
   end

   // input beat capture
   logic                      kind_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [MOVE_W-1:0]         move_ff;
   logic [SCORE_W-1:0]        score_ff;
   logic signed [DEPTH_W-1:0] depth_ff;
   logic [EVAL_W-1:0]         eval_ff;
   logic [BOUND_W-1:0]        bound_ff;
   logic [DW-1:0]             div_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         move_ff  <= req_move_code;
         score_ff <= req_move_score;
         depth_ff <= req_search_depth;
         eval_ff  <= req_eval_value;
         bound_ff <= req_bound_type;
         div_ff   <= divisor;
      end
   end

   // restoring divider, one quotient bit a cycle, remainder only
   logic [KEY_W-1:0] shift_ff;
   logic [DW-1:0]    rem_ff;
   logic [DCW-1:0]   dcnt_ff;
   logic [DW:0]      trial;
   logic [DW:0]      rem_sh;
   assign rem_sh = {rem_ff, shift_ff[KEY_W-1]};
   assign trial  = rem_sh - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.load) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         shift_ff <= req_key;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         shift_ff <= {shift_ff[KEY_W-2:0], 1'b0};
         rem_ff   <= trial[DW] ? rem_sh[DW-1:0] : trial[DW-1:0];
      end
   end

   assign status.div_done = (dcnt_ff == DCW'(KEY_W));

   logic [AW-1:0] idx;
   assign idx = rem_ff[AW-1:0];

   // clearing pass after reset: every word is set to the empty entry,
   // so a slot never written reads as key 0 with no move
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign status.clear_done = (clr_ff == AW'(ENTRIES - 1));

   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_word;
   logic              wr_en;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     idx_rd_ff;

   assign ram_we    = cmd.clear || wr_en;
   assign ram_waddr = cmd.clear ? clr_ff : idx_rd_ff;
   assign ram_wdata = cmd.clear ? EMPTY_WORD : wr_data;

   htdr_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx),
      .rd_data (rd_word)
   );

   // slot index kept for the write back
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         idx_rd_ff <= idx;
      end
   end

   // current slot contents
   logic [KEY_W-1:0]          c_key;
   logic [MOVE_W-1:0]         c_move;
   logic [SCORE_W-1:0]        c_score;
   logic signed [DEPTH_W-1:0] c_depth;
   logic [EVAL_W-1:0]         c_eval;
   logic [BOUND_W-1:0]        c_bound;
   always_comb begin
      {c_key, c_move, c_score, c_depth, c_eval, c_bound} = rd_word;
   end

   logic hit, replace;
   assign hit     = (c_key == key_ff);
   assign replace = (kind_ff == KIND_STORE) &&
                    (!hit || (depth_ff >= c_depth) || (bound_ff == EXACT));
   assign wr_en   = cmd.commit && replace;
   assign wr_data = {key_ff, move_ff, score_ff, depth_ff, eval_ff, bound_ff};

   // occupancy over the first sample slots
   logic [CNT_W-1:0] occ_ff;
   logic in_sample, was_occ, now_occ;
   assign in_sample = ({{(32 - AW){1'b0}}, idx_rd_ff} < 32'(FILL_SAMPLE));
   assign was_occ   = (c_move != NO_MOVE);
   assign now_occ   = (move_ff != NO_MOVE);
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (wr_en && in_sample) begin
         if (now_occ && !was_occ) begin
            occ_ff <= occ_ff + CNT_W'(1);
         end else if (was_occ && !now_occ) begin
            occ_ff <= occ_ff - CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_hit     <= hit;
         rsp_written <= replace;
         if (replace) begin
            {rsp_slot_key, rsp_slot_move, rsp_slot_score, rsp_slot_depth,
             rsp_slot_eval, rsp_slot_bound} <= wr_data;
         end else begin
            {rsp_slot_key, rsp_slot_move, rsp_slot_score, rsp_slot_depth,
             rsp_slot_eval, rsp_slot_bound} <=
               {c_key, c_move, c_score, c_depth, c_eval, c_bound};
         end
      end
   end

   // fill count after the commit
   always_comb begin
      rsp_fill_count = occ_ff;
   end

endmodule
